// ----- design/lru_pr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Port widths and fixed constants shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

	localparam int PAGE_PORT_W = 16;   // width of page_number and evicted_page
	localparam int SLOT_PORT_W = 4;    // width of frame_slot
	localparam int CFG_W       = 5;    // width of cfg_data, the frames_in_use write value
	localparam int FAULT_W     = 16;   // width of the fault counter

	localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(16);
	localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

	// Status of the word held in the result register
	typedef struct packed {
		logic page_fault;
		logic evicted_valid;
	} lru_pr_status_t;

endpackage

// ----- design/lru_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Looks up one page reference per word in a table of resident pages and
// replaces the least recently used page on a miss once the table is full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries page_number and restart_run.
//   Output channel (out_valid / out_stall) carries page_fault, frame_slot,
//   evicted_valid, evicted_page and total_faults, one word per input word.
//   The config channel (cfg_valid / cfg_ready / cfg_data) writes
//   frames_in_use; a write also empties the table and zeroes the fault count.
//   Write it only while no reference is in flight.
// Pipeline and throughput:
//   A word passes from the input register to the result register, which
//   drives the output. One word per cycle is sustained while out_stall is
//   low: the lookup, victim pick and rank update for all frames are done
//   by one parallel compare over every slot between the two registers.
// Reset:
//   arst_n empties the table, clears the fault count and sets frames_in_use
//   to 16 (bounded by NUM_FRAMES).
// Stall:
//   When out_stall holds a full result register, the input register holds too
//   and in_stall rises until the result word is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit
	import lru_pr_pkg::*;
#(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// config write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [PAGE_PORT_W-1:0] page_number,
	input  logic                   restart_run,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   page_fault,
	output logic [SLOT_PORT_W-1:0] frame_slot,
	output logic                   evicted_valid,
	output logic [PAGE_PORT_W-1:0] evicted_page,
	output logic [FAULT_W-1:0]     total_faults
);

	localparam int SW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FPW = $clog2(NUM_FRAMES + 1);
	localparam int FRAMES_INIT = (32'(FRAMES_RESET) > NUM_FRAMES) ?
		NUM_FRAMES : 32'(FRAMES_RESET);

	// control state
	logic                  s1_valid_q;
	logic                  out_valid_q;
	logic [NUM_FRAMES-1:0] valid_q;
	logic [FPW-1:0]        fill_ptr_q;
	logic [FAULT_W-1:0]    fault_cnt_q;
	logic [FPW-1:0]        frames_q;

	// payload
	logic [PAGE_PORT_W-1:0] page_s1;
	logic                   restart_s1;
	logic [PAGE_BITS-1:0]   page_q [NUM_FRAMES];
	logic [SW-1:0]          rank_q [NUM_FRAMES];
	lru_pr_status_t         status_q;
	logic [SW-1:0]          slot_q;
	logic [PAGE_PORT_W-1:0] evicted_page_q;

	// datapath
	logic                  advance;
	logic                  in_take;
	logic                  cfg_take;
	logic [FPW-1:0]        cfg_frames;
	logic [PAGE_BITS-1:0]  page_w;
	logic [NUM_FRAMES-1:0] valid_eff;
	logic [FPW-1:0]        fill_eff;
	logic [FAULT_W-1:0]    fault_eff;
	logic [NUM_FRAMES-1:0] hit_vec;
	logic [NUM_FRAMES-1:0] vict_vec;
	logic [SW-1:0]         hit_idx;
	logic [SW-1:0]         vict_idx;
	logic                  hit;
	logic                  fill_free;
	logic                  evict;
	logic [SW-1:0]         slot;
	logic [SW-1:0]         hit_rank;
	logic [PAGE_BITS-1:0]  old_page;
	logic [NUM_FRAMES-1:0] valid_nxt;
	logic [FPW-1:0]        fill_nxt;
	logic [FAULT_W-1:0]    fault_nxt;
	logic [SW-1:0]         rank_nxt [NUM_FRAMES];

	assign advance   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = !s1_valid_q;
	assign cfg_take  = cfg_valid && cfg_ready;

	// bound the frame count to 1..NUM_FRAMES at write time
	always_comb begin
		if (cfg_data == '0) begin
			cfg_frames = FPW'(1);
		end else if (32'(cfg_data) > NUM_FRAMES) begin
			cfg_frames = FPW'(NUM_FRAMES);
		end else begin
			cfg_frames = FPW'(cfg_data);
		end
	end

	// restart empties the table and zeroes the fault count before the lookup
	assign page_w    = PAGE_BITS'(32'(page_s1));
	assign valid_eff = restart_s1 ? '0 : valid_q;
	assign fill_eff  = restart_s1 ? '0 : fill_ptr_q;
	assign fault_eff = restart_s1 ? '0 : fault_cnt_q;

	always_comb begin
		for (int t = 0; t < NUM_FRAMES; t++) begin
			hit_vec[t]  = valid_eff[t] && (page_q[t] == page_w);
			// the oldest valid slot holds rank frames-1 once the table is full
			vict_vec[t] = valid_eff[t] && (FPW'(rank_q[t]) == frames_q - FPW'(1));
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit_idx  = '0;
		vict_idx = '0;
		for (int t = NUM_FRAMES - 1; t >= 0; t--) begin
			if (hit_vec[t]) begin
				hit_idx = SW'(t);
			end
			if (vict_vec[t]) begin
				vict_idx = SW'(t);
			end
		end
	end

	assign hit       = |hit_vec;
	assign fill_free = fill_eff < frames_q;
	assign evict     = !hit && !fill_free;
	assign hit_rank  = rank_q[hit_idx];
	assign old_page  = evict ? page_q[vict_idx] : '0;

	always_comb begin
		if (hit) begin
			slot = hit_idx;
		end else if (fill_free) begin
			slot = SW'(fill_eff);
		end else begin
			slot = vict_idx;
		end
	end

	// a hit ages newer slots, a miss ages all valid ones; the touched one is newest
	always_comb begin
		for (int t = 0; t < NUM_FRAMES; t++) begin
			if (SW'(t) == slot) begin
				rank_nxt[t] = '0;
			end else if (valid_eff[t] && (!hit || rank_q[t] < hit_rank)) begin
				rank_nxt[t] = rank_q[t] + SW'(1);
			end else begin
				rank_nxt[t] = rank_q[t];
			end
		end
	end

	always_comb begin
		valid_nxt = valid_eff;
		if (!hit) begin
			valid_nxt[slot] = 1'b1;
		end
	end

	assign fill_nxt  = (!hit && fill_free) ? fill_eff + FPW'(1) : fill_eff;
	assign fault_nxt = (!hit && fault_eff != FAULT_MAX) ? fault_eff + FAULT_W'(1) : fault_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			fill_ptr_q  <= '0;
			fault_cnt_q <= '0;
			frames_q    <= FPW'(FRAMES_INIT);
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_take) begin
				frames_q    <= cfg_frames;
				valid_q     <= '0;
				fill_ptr_q  <= '0;
				fault_cnt_q <= '0;
			end else if (advance) begin
				valid_q     <= valid_nxt;
				fill_ptr_q  <= fill_nxt;
				fault_cnt_q <= fault_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			page_s1    <= page_number;
			restart_s1 <= restart_run;
		end
		if (advance) begin
			if (!hit) begin
				page_q[slot] <= page_w;
			end
			for (int t = 0; t < NUM_FRAMES; t++) begin
				rank_q[t] <= rank_nxt[t];
			end
			status_q.page_fault    <= !hit;
			status_q.evicted_valid <= evict;
			slot_q                 <= slot;
			evicted_page_q         <= PAGE_PORT_W'(32'(old_page));
			total_faults           <= fault_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign page_fault    = status_q.page_fault;
	assign evicted_valid = status_q.evicted_valid;
	assign frame_slot    = SLOT_PORT_W'(32'(slot_q));
	assign evicted_page  = evicted_page_q;

`ifndef NO_ASSERTIONS
	// slots fill in order, so the fill pointer counts the valid slots
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(fill_ptr_q))
		else $error("fill pointer does not match valid slot count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_ptr_q <= frames_q)
		else $error("fill pointer beyond active frames");

	a_evict_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q.evicted_valid |-> status_q.page_fault)
		else $error("eviction reported on a hit");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q.page_fault |-> total_faults != '0)
		else $error("fault reported with zero fault total");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Sends page references through the unit while both channels idle at random,
// and checks every result word against a planned value or a behavioral copy of
// the frame table, its recency ranks and the saturating fault counter.
// ----------------------------------------------------------------------------
module testbench
	import lru_pr_pkg::*;
();

	localparam int FRAMES_MAX   = 16;
	localparam int PAGE_BITS    = 16;
	localparam int HOLD_CYCLES  = 48;
	localparam int DRAIN_CYCLES = 6;
	localparam int END_LIMIT    = 4000;
	localparam int PHASES       = 12;
	localparam int PHASE_WORDS  = 153;
	localparam int PLAN_ROWS    = 25;

	typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_OFF} idle_mode_t;

	typedef struct packed {
		logic                   fault;
		logic [SLOT_PORT_W-1:0] slot;
		logic                   evicted;
		logic [PAGE_PORT_W-1:0] victim;
		logic [FAULT_W-1:0]     faults;
	} page_result_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_W-1:0]       frames;
		logic [PAGE_PORT_W-1:0] page;
		logic                   restart;
		logic                   typed;
		page_result_t           want;
	} plan_row_t;

	// kind, frames, page, restart, typed, {fault, slot, evicted, victim, faults}
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_REF, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
		'{ROW_REF, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 16'd2}},
		'{ROW_REF, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd2}},
		'{ROW_REF, 5'd0,  16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
		'{ROW_CFG, 5'd1,  16'h0000, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h1234, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
		'{ROW_REF, 5'd0,  16'h5678, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'h1234, 16'd2}},
		'{ROW_REF, 5'd0,  16'h5678, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd2}},
		'{ROW_CFG, 5'd0,  16'h0000, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'hAAAA, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1}},
		'{ROW_REF, 5'd0,  16'h5555, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 16'hAAAA, 16'd2}},
		'{ROW_CFG, 5'd3,  16'h0000, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0001, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0002, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0003, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0001, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0004, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0003, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0005, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h0004, 1'b1, 1'b0, '0},
		'{ROW_CFG, 5'd31, 16'h0000, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h8000, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0},
		'{ROW_REF, 5'd0,  16'h8000, 1'b0, 1'b0, '0},
		'{ROW_CFG, 5'd16, 16'h0000, 1'b0, 1'b0, '0}
	};

	localparam logic [CFG_W-1:0] PHASE_FRAMES [8] = '{
		5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd5, 5'd8, 5'd17
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [PAGE_PORT_W-1:0] page_number;
	logic                   restart_run;
	logic                   out_valid;
	logic                   out_stall;
	logic                   page_fault;
	logic [SLOT_PORT_W-1:0] frame_slot;
	logic                   evicted_valid;
	logic [PAGE_PORT_W-1:0] evicted_page;
	logic [FAULT_W-1:0]     total_faults;

	// behavioral frame table
	logic [PAGE_PORT_W-1:0] frame_page [FRAMES_MAX];
	bit                     frame_used [FRAMES_MAX];
	int                     frame_age  [FRAMES_MAX];
	int                     next_free;
	logic [FAULT_W-1:0]     fault_count;
	logic [CFG_W-1:0]       frames_reg;

	page_result_t pending_results [$];
	int           error_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_requests = 0;

	lru_page_replacement_unit #(
		.NUM_FRAMES(FRAMES_MAX),
		.PAGE_BITS (PAGE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_number  (page_number),
		.restart_run  (restart_run),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.page_fault   (page_fault),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.total_faults (total_faults)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int active_frames(input logic [CFG_W-1:0] frames);
		if (frames == 0)
			return 1;
		if (frames > FRAMES_MAX)
			return FRAMES_MAX;
		return int'(frames);
	endfunction

	function automatic void clear_table();
		for (int t = 0; t < FRAMES_MAX; t++) begin
			frame_page[t] = '0;
			frame_used[t] = 1'b0;
			frame_age[t]  = 0;
		end
		next_free   = 0;
		fault_count = '0;
	endfunction

	// Handle one reference and return the result word it produces.
	function automatic page_result_t lookup_page(input logic [PAGE_PORT_W-1:0] page,
			input logic restart);
		page_result_t res;
		int           active;
		int           s;
		int           limit;
		int           oldest;
		bit           hit;
		res = '0;
		if (restart)
			clear_table();
		active = active_frames(frames_reg);
		hit    = 1'b0;
		s      = 0;
		for (int t = 0; t < active; t++) begin
			if (!hit && frame_used[t] && frame_page[t] == page) begin
				hit = 1'b1;
				s   = t;
			end
		end
		// a hit ages only the slots that were more recent than it
		limit = 1 << 30;
		if (hit) begin
			limit = frame_age[s];
		end else begin
			if (next_free < active) begin
				s = next_free;
				next_free++;
			end else begin
				// strict compare keeps the lowest slot on a tie
				oldest = -1;
				for (int t = 0; t < active; t++) begin
					if (frame_used[t] && frame_age[t] > oldest) begin
						oldest = frame_age[t];
						s      = t;
					end
				end
				res.evicted = 1'b1;
				res.victim  = frame_page[s];
			end
			frame_page[s] = page;
			frame_used[s] = 1'b1;
			if (fault_count != FAULT_MAX)
				fault_count++;
		end
		for (int t = 0; t < active; t++) begin
			if (t != s && frame_used[t] && frame_age[t] < limit)
				frame_age[t]++;
		end
		frame_age[s] = 0;
		res.fault  = !hit;
		res.slot   = SLOT_PORT_W'(s);
		res.faults = fault_count;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
				want, got);
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t ns: result word with none expected, expected none, actual %0h",
					$time, {page_fault, frame_slot, evicted_valid, evicted_page,
					total_faults});
			end else begin
				want = pending_results.pop_front();
				check_field("page_fault", 32'(want.fault), 32'(page_fault));
				check_field("frame_slot", 32'(want.slot), 32'(frame_slot));
				check_field("evicted_valid", 32'(want.evicted), 32'(evicted_valid));
				check_field("evicted_page", 32'(want.victim), 32'(evicted_page));
				check_field("total_faults", 32'(want.faults), 32'(total_faults));
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct;
			end
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_RECV_HEAVY: begin
				send_idle_pct = 34;
				recv_idle_pct = 75;
			end
			IDLE_SEND_HEAVY: begin
				send_idle_pct = 75;
				recv_idle_pct = 34;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offer one word; hold it until accepted, then queue its expected result.
	task automatic send_word(input logic [PAGE_PORT_W-1:0] page, input logic restart,
			input logic typed, input page_result_t want);
		page_result_t predicted;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= page;
		restart_run <= restart;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = lookup_page(page, restart);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		frames_reg = value;
		clear_table();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random references drawn mostly from a working set of up to three pages
	// more than the active frame count, so hits and evictions both stay common.
	task automatic run_phase(input logic [CFG_W-1:0] frames);
		logic [PAGE_PORT_W-1:0] pool [FRAMES_MAX + 4];
		logic [PAGE_PORT_W-1:0] page;
		int                     pool_size;
		write_frames(frames);
		pool_size = active_frames(frames) + $urandom_range(0, 3);
		for (int n = 0; n < pool_size; n++)
			pool[n] = PAGE_PORT_W'($urandom_range(0, 16'hFFFF));
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (n == PHASE_WORDS / 3)
				wait_idle();
			if (n == PHASE_WORDS / 2)
				hold_requests++;
			if ($urandom_range(0, 99) < 8)
				page = PAGE_PORT_W'($urandom_range(0, 16'hFFFF));
			else
				page = pool[$urandom_range(0, pool_size - 1)];
			send_word(page, $urandom_range(0, 49) == 0, 1'b0, '0);
		end
	endtask

	initial begin
		int waited;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		page_number = '0;
		restart_run = 1'b0;
		frames_reg  = FRAMES_RESET;
		clear_table();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		set_idle(IDLE_RECV_HEAVY);
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_CFG)
				write_frames(PLAN[i].frames);
			else
				send_word(PLAN[i].page, PLAN[i].restart, PLAN[i].typed, PLAN[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_idle(idle_mode_t'(p * 3 / PHASES));
			run_phase(p < 8 ? PHASE_FRAMES[p] : CFG_W'($urandom_range(0, 31)));
		end

		// restart after random traffic: the table and the fault count start over
		send_word(16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1});

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < END_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0t ns: missing results, expected 0 pending, actual %0d pending",
				$time, pending_results.size());
		end
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("%0t ns: timeout", $time);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
